FILE: hdl/i2cmbs_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbs_pkg
// Types and constants for the I2C master bit sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbs_pkg;

    localparam int BYTE_W  = 8;
    localparam int PHASE_W = 6;
    localparam int MODE_W  = 3;

    localparam logic [MODE_W-1:0] MODE_TICK  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_START = 3'd1;
    localparam logic [MODE_W-1:0] MODE_STOP  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_WAIT  = 3'd5;

    // last phase of the start and write commands
    localparam logic [PHASE_W-1:0] START_LAST = 6'd3;
    localparam logic [PHASE_W-1:0] WRITE_LAST = 6'd31;

    typedef enum logic [5:0] {
        CMD_NONE  = 6'b000001,
        CMD_START = 6'b000010,
        CMD_STOP  = 6'b000100,
        CMD_WRITE = 6'b001000,
        CMD_READ  = 6'b010000,
        CMD_WAIT  = 6'b100000
    } cmd_t;

    typedef struct packed {
        logic              nack_seen;
        logic [BYTE_W-1:0] read_data;
        logic              busy_res;
        logic              sda_drive;
        logic              sda_out;
        logic              scl;
    } res_t;

endpackage

`default_nettype wire

FILE: hdl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Bit-level I2C master pin sequencer: latches commands, steps one bus phase
// per tick item and reports the pin levels after each tick.
// ----------------------------------------------------------------------------
// A tick item's result is registered on the master side, via the skid register while the output stalls.
// Throughput: one item per cycle while the skid register is empty; the two-entry result buffer keeps input
// ready while one result waits.
// Commands give no result. Reset (async, rst_n low): no command, SCL and SDA
// high with SDA driven, result buffer empty.
`default_nettype none

module i2c_master_bit_sequencer
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // wr_data[7:0], send_nack, sda_level, zeros
    input  wire logic [2:0]  s_axis_tuser,  // mode
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [15:0] m_axis_tdata,  // scl, sda_out, sda_drive, busy_res,
                                            // read_data[7:0], nack_seen, zeros
    output      logic        m_axis_tlast   // done_res
);

    localparam int BW = i2cmbs_pkg::BYTE_W;
    localparam int PW = i2cmbs_pkg::PHASE_W;
    localparam int RW = $bits(i2cmbs_pkg::res_t);

    i2cmbs_pkg::cmd_t cmd_reg, cmd_next;
    logic [PW-1:0]    phase_reg, phase_next;
    logic [BW-1:0]    shift_reg, shift_next;
    logic             nack_choice_reg, nack_choice_next;
    logic             scl_reg, scl_next;
    logic             sda_reg, sda_next;
    logic             sda_en_reg, sda_en_next;
    logic             ack_flag_reg, ack_flag_next;

    i2cmbs_pkg::res_t out_reg, skid_reg, res_new;
    logic             out_done_reg, skid_done_reg, done;
    logic             out_valid_reg, skid_valid_reg;

    logic [2:0]    mode;
    logic [BW-1:0] wr_data;
    logic          send_nack;
    logic          sda_level;
    logic          accept;
    logic          produce;
    logic [1:0]    bit_ph;
    logic [BW-1:0] rd;
    logic          nk;

    assign mode      = s_axis_tuser;
    assign wr_data   = s_axis_tdata[BW-1:0];
    assign send_nack = s_axis_tdata[BW];
    assign sda_level = s_axis_tdata[BW+1];

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign produce       = accept && (mode == i2cmbs_pkg::MODE_TICK);
    assign bit_ph        = phase_reg[1:0];

    always_comb
    begin
        cmd_next         = cmd_reg;
        phase_next       = phase_reg;
        shift_next       = shift_reg;
        nack_choice_next = nack_choice_reg;
        scl_next         = scl_reg;
        sda_next         = sda_reg;
        sda_en_next      = sda_en_reg;
        ack_flag_next    = ack_flag_reg;
        done             = 1'b0;
        rd               = '0;
        nk               = 1'b0;

        if (accept && mode != i2cmbs_pkg::MODE_TICK)
        begin
            if (cmd_reg == i2cmbs_pkg::CMD_NONE)
            begin
                case (mode)
                    i2cmbs_pkg::MODE_START: cmd_next = i2cmbs_pkg::CMD_START;
                    i2cmbs_pkg::MODE_STOP:  cmd_next = i2cmbs_pkg::CMD_STOP;
                    i2cmbs_pkg::MODE_WRITE: cmd_next = i2cmbs_pkg::CMD_WRITE;
                    i2cmbs_pkg::MODE_READ:  cmd_next = i2cmbs_pkg::CMD_READ;
                    i2cmbs_pkg::MODE_WAIT:  cmd_next = i2cmbs_pkg::CMD_WAIT;
                    default:                cmd_next = i2cmbs_pkg::CMD_NONE;
                endcase
                if (mode inside {[i2cmbs_pkg::MODE_START : i2cmbs_pkg::MODE_WAIT]})
                begin
                    phase_next       = '0;
                    shift_next       = (mode == i2cmbs_pkg::MODE_WRITE) ? wr_data : '0;
                    nack_choice_next = send_nack;
                    if (mode == i2cmbs_pkg::MODE_WAIT)
                        ack_flag_next = 1'b0;
                end
            end
        end
        else if (produce)
        begin
            case (cmd_reg)
                i2cmbs_pkg::CMD_START:
                begin
                    case (phase_reg)
                        6'd0:
                        begin
                            sda_en_next = 1'b1;
                            scl_next    = 1'b1;
                        end
                        6'd1:    sda_next = 1'b1;
                        6'd2:    sda_next = 1'b0;
                        default:
                        begin
                            scl_next = 1'b0;
                            done     = 1'b1;
                        end
                    endcase
                end
                i2cmbs_pkg::CMD_STOP:
                begin
                    case (phase_reg)
                        6'd0:
                        begin
                            sda_en_next = 1'b1;
                            scl_next    = 1'b0;
                        end
                        6'd1:    sda_next = 1'b0;
                        6'd2:    scl_next = 1'b1;
                        default:
                        begin
                            sda_next = 1'b1;
                            done     = 1'b1;
                        end
                    endcase
                end
                i2cmbs_pkg::CMD_WRITE:
                begin
                    case (bit_ph)
                        2'd0:
                        begin
                            sda_en_next = 1'b1;
                            scl_next    = 1'b0;
                        end
                        2'd1:    sda_next = shift_reg[BW-1];
                        2'd2:    scl_next = 1'b1;
                        default: shift_next = {shift_reg[BW-2:0], 1'b0};
                    endcase
                    done = (phase_reg >= i2cmbs_pkg::WRITE_LAST);
                end
                i2cmbs_pkg::CMD_READ:
                begin
                    if (!phase_reg[PW-1])
                    begin
                        case (bit_ph)
                            2'd0:
                            begin
                                sda_en_next = 1'b0;
                                scl_next    = 1'b0;
                            end
                            2'd2:    scl_next   = 1'b1;
                            2'd3:    shift_next = {shift_reg[BW-2:0], sda_level};
                            default: ;
                        endcase
                    end
                    else
                    begin
                        case (phase_reg[PW-2:0])
                            5'd0:
                            begin
                                sda_en_next = 1'b1;
                                scl_next    = 1'b0;
                            end
                            5'd1: sda_next = nack_choice_reg;
                            5'd2: scl_next = 1'b1;
                            5'd3: ;
                            default:
                            begin
                                scl_next = 1'b0;
                                done     = 1'b1;
                                rd       = shift_reg;
                            end
                        endcase
                    end
                end
                i2cmbs_pkg::CMD_WAIT:
                begin
                    case (phase_reg)
                        6'd0: scl_next    = 1'b0;
                        6'd1: sda_next    = 1'b1;
                        6'd2: sda_en_next = 1'b0;
                        6'd3: scl_next    = 1'b1;
                        default:
                        begin
                            ack_flag_next = sda_level;
                            if (!sda_level)
                                scl_next = 1'b0;
                            done = 1'b1;
                            nk   = sda_level;
                        end
                    endcase
                end
                default: ;
            endcase

            if (cmd_reg != i2cmbs_pkg::CMD_NONE)
            begin
                if (done)
                begin
                    cmd_next   = i2cmbs_pkg::CMD_NONE;
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        res_new.scl       = scl_next;
        res_new.sda_out   = sda_next;
        res_new.sda_drive = sda_en_next;
        res_new.busy_res  = (cmd_next != i2cmbs_pkg::CMD_NONE);
        res_new.read_data = rd;
        res_new.nack_seen = nk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg         <= i2cmbs_pkg::CMD_NONE;
            phase_reg       <= '0;
            shift_reg       <= '0;
            nack_choice_reg <= 1'b0;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
            sda_en_reg      <= 1'b1;
            ack_flag_reg    <= 1'b0;
        end
        else
        begin
            cmd_reg         <= cmd_next;
            phase_reg       <= phase_next;
            shift_reg       <= shift_next;
            nack_choice_reg <= nack_choice_next;
            scl_reg         <= scl_next;
            sda_reg         <= sda_next;
            sda_en_reg      <= sda_en_next;
            ack_flag_reg    <= ack_flag_next;
        end
    end

    // result register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= produce;
            end
        end
        else if (produce)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_axis_tready)
        begin
            if (skid_valid_reg)
            begin
                out_reg      <= skid_reg;
                out_done_reg <= skid_done_reg;
            end
            else
            begin
                out_reg      <= res_new;
                out_done_reg <= done;
            end
        end
        else if (produce)
        begin
            skid_reg      <= res_new;
            skid_done_reg <= done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(16-RW){1'b0}}, out_reg};
    assign m_axis_tlast  = out_done_reg;

endmodule

`default_nettype wire

FILE: bench/i2c_master_bit_sequencer_tb.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer_tb
// Self-checking bench for the I2C master bit sequencer. Drives command and
// tick items with random idle and back-pressure. A scoreboard steps its own
// copy of the pin sequencer on every accepted item and compares each tick
// result field by field. The random part is mostly complete command runs
// with random bus levels, mixed with stray and reserved commands.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_sequencer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BW  = i2cmbs_pkg::BYTE_W;
    localparam int PHW = i2cmbs_pkg::PHASE_W;
    localparam int MW  = i2cmbs_pkg::MODE_W;

    localparam logic [MW-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MW-1:0] MODE_RSVD7 = 3'd7;

    localparam int START_TICKS = 4;
    localparam int STOP_TICKS  = 4;
    localparam int WRITE_TICKS = 32;
    localparam int READ_TICKS  = 37;
    localparam int WAIT_TICKS  = 5;

    localparam int ITEM_TARGET = 700;
    localparam int QUIET_AFTER = 600;
    localparam int STALL_AT    = 150;
    localparam int STALL_LEN   = 80;

    typedef struct {
        i2cmbs_pkg::res_t pins;
        logic             done;
    } tick_result_t;

    class pin_scoreboard;
        i2cmbs_pkg::cmd_t cmd;
        logic [PHW-1:0]   phase;
        logic [BW-1:0]    shreg;
        logic             nack_sel;
        logic             scl_q;
        logic             sda_q;
        logic             drv_q;
        logic             ack_q;
        tick_result_t     expected_ticks[$];
        int               fails;
        int               checked;
        int               completions;

        function new();
            cmd         = i2cmbs_pkg::CMD_NONE;
            phase       = '0;
            shreg       = '0;
            nack_sel    = 1'b0;
            scl_q       = 1'b1;
            sda_q       = 1'b1;
            drv_q       = 1'b1;
            ack_q       = 1'b0;
            fails       = 0;
            checked     = 0;
            completions = 0;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        function void note_item(logic [MW-1:0] mode, logic [BW-1:0] wr,
                                logic snack, logic sda_in);
            i2cmbs_pkg::cmd_t nc;
            logic [PHW-1:0]   p;
            logic [PHW-1:0]   q;
            logic             done;
            logic [BW-1:0]    rd;
            logic             nk;
            tick_result_t     r;
            done = 1'b0;
            rd   = '0;
            nk   = 1'b0;
            if (mode != i2cmbs_pkg::MODE_TICK)
            begin
                case (mode)
                    i2cmbs_pkg::MODE_START: nc = i2cmbs_pkg::CMD_START;
                    i2cmbs_pkg::MODE_STOP:  nc = i2cmbs_pkg::CMD_STOP;
                    i2cmbs_pkg::MODE_WRITE: nc = i2cmbs_pkg::CMD_WRITE;
                    i2cmbs_pkg::MODE_READ:  nc = i2cmbs_pkg::CMD_READ;
                    i2cmbs_pkg::MODE_WAIT:  nc = i2cmbs_pkg::CMD_WAIT;
                    default:                nc = i2cmbs_pkg::CMD_NONE;
                endcase
                if (cmd == i2cmbs_pkg::CMD_NONE && nc != i2cmbs_pkg::CMD_NONE)
                begin
                    cmd      = nc;
                    phase    = '0;
                    shreg    = (nc == i2cmbs_pkg::CMD_WRITE) ? wr : '0;
                    nack_sel = snack;
                    if (nc == i2cmbs_pkg::CMD_WAIT)
                        ack_q = 1'b0;
                end
                return;
            end
            p = phase;
            case (cmd)
                i2cmbs_pkg::CMD_START:
                begin
                    if (p == 0)
                    begin
                        drv_q = 1'b1;
                        scl_q = 1'b1;
                    end
                    else if (p == 1) sda_q = 1'b1;
                    else if (p == 2) sda_q = 1'b0;
                    else
                    begin
                        scl_q = 1'b0;
                        done  = 1'b1;
                    end
                end
                i2cmbs_pkg::CMD_STOP:
                begin
                    if (p == 0)
                    begin
                        drv_q = 1'b1;
                        scl_q = 1'b0;
                    end
                    else if (p == 1) sda_q = 1'b0;
                    else if (p == 2) scl_q = 1'b1;
                    else
                    begin
                        sda_q = 1'b1;
                        done  = 1'b1;
                    end
                end
                i2cmbs_pkg::CMD_WRITE:
                begin
                    case (p[1:0])
                        2'd0:
                        begin
                            drv_q = 1'b1;
                            scl_q = 1'b0;
                        end
                        2'd1:    sda_q = shreg[BW-1];
                        2'd2:    scl_q = 1'b1;
                        default: shreg = shreg << 1;
                    endcase
                    if (p >= 31)
                        done = 1'b1;
                end
                i2cmbs_pkg::CMD_READ:
                begin
                    if (p < 32)
                    begin
                        if (p[1:0] == 2'd0)
                        begin
                            drv_q = 1'b0;
                            scl_q = 1'b0;
                        end
                        else if (p[1:0] == 2'd2) scl_q = 1'b1;
                        else if (p[1:0] == 2'd3) shreg = {shreg[BW-2:0], sda_in};
                    end
                    else
                    begin
                        q = p - 6'd32;
                        if (q == 0)
                        begin
                            drv_q = 1'b1;
                            scl_q = 1'b0;
                        end
                        else if (q == 1) sda_q = nack_sel;
                        else if (q == 2) scl_q = 1'b1;
                        else if (q >= 4)
                        begin
                            scl_q = 1'b0;
                            done  = 1'b1;
                            rd    = shreg;
                        end
                    end
                end
                i2cmbs_pkg::CMD_WAIT:
                begin
                    if (p == 0) scl_q = 1'b0;
                    else if (p == 1) sda_q = 1'b1;
                    else if (p == 2) drv_q = 1'b0;
                    else if (p == 3) scl_q = 1'b1;
                    else
                    begin
                        ack_q = sda_in;
                        if (!ack_q)
                            scl_q = 1'b0;
                        done = 1'b1;
                        nk   = ack_q;
                    end
                end
                default: ;
            endcase
            if (cmd != i2cmbs_pkg::CMD_NONE)
            begin
                if (done)
                begin
                    cmd   = i2cmbs_pkg::CMD_NONE;
                    phase = '0;
                end
                else
                begin
                    phase = p + 1'b1;
                end
            end
            r.pins.scl       = scl_q;
            r.pins.sda_out   = sda_q;
            r.pins.sda_drive = drv_q;
            r.pins.busy_res  = (cmd != i2cmbs_pkg::CMD_NONE);
            r.pins.read_data = rd;
            r.pins.nack_seen = nk;
            r.done           = done;
            expected_ticks.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned expv, int unsigned gotv);
            if (expv != gotv)
            begin
                $error("%s mismatch: expected %0h, got %0h", name, expv, gotv);
                fails++;
            end
        endfunction

        function void check_result(logic [15:0] data, logic last);
            tick_result_t     e;
            i2cmbs_pkg::res_t got;
            if (expected_ticks.size() == 0)
            begin
                $error("unexpected result item: tdata %0h tlast %0b", data, last);
                fails++;
                return;
            end
            e   = expected_ticks.pop_front();
            got = i2cmbs_pkg::res_t'(data[12:0]);
            checked++;
            if (e.done)
                completions++;
            compare_field("scl", e.pins.scl, got.scl);
            compare_field("sda_out", e.pins.sda_out, got.sda_out);
            compare_field("sda_drive", e.pins.sda_drive, got.sda_drive);
            compare_field("busy_res", e.pins.busy_res, got.busy_res);
            compare_field("done_res", e.done, last);
            compare_field("read_data", e.pins.read_data, got.read_data);
            compare_field("nack_seen", e.pins.nack_seen, got.nack_seen);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    pin_scoreboard sb;
    int            items_sent;
    int            results_seen;
    bit            quiet;
    bit            stalled_once;

    i2c_master_bit_sequencer DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // input side noted before the result check in case both land on one edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8],
                             s_axis_tdata[9]);
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_result(m_axis_tdata, m_axis_tlast);
                results_seen++;
            end
        end
    end

    task automatic send_item(input logic [MW-1:0] mode, input logic [BW-1:0] wr,
                             input logic snack, input logic sda);
        int gap;
        begin
            gap = 0;
            if (!quiet && $urandom_range(0, 5) == 0)
                gap = $urandom_range(1, 14);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            s_axis_tdata  <= {6'd0, sda, snack, wr};
            s_axis_tuser  <= mode;
            s_axis_tvalid <= 1'b1;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            items_sent++;
        end
    endtask

    task automatic tick(input logic sda);
        begin
            send_item(i2cmbs_pkg::MODE_TICK, BW'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)), sda);
        end
    endtask

    task automatic command(input logic [MW-1:0] mode, input logic [BW-1:0] wr,
                           input logic snack);
        begin
            send_item(mode, wr, snack, 1'($urandom_range(0, 1)));
        end
    endtask

    function automatic logic [MW-1:0] any_command();
        case ($urandom_range(0, 4))
            0:       return i2cmbs_pkg::MODE_START;
            1:       return i2cmbs_pkg::MODE_STOP;
            2:       return i2cmbs_pkg::MODE_WRITE;
            3:       return i2cmbs_pkg::MODE_READ;
            default: return i2cmbs_pkg::MODE_WAIT;
        endcase
    endfunction

    function automatic logic [BW-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BW'($urandom_range(0, 255));
        endcase
    endfunction

    // one complete command run with random bus levels, sometimes disturbed
    task automatic run_sequence();
        logic [MW-1:0] mode;
        int            len;
        int            i;
        begin
            mode = any_command();
            case (mode)
                i2cmbs_pkg::MODE_START: len = START_TICKS;
                i2cmbs_pkg::MODE_STOP:  len = STOP_TICKS;
                i2cmbs_pkg::MODE_WRITE: len = WRITE_TICKS;
                i2cmbs_pkg::MODE_READ:  len = READ_TICKS;
                default:                len = WAIT_TICKS;
            endcase
            command(mode, pick_byte(), 1'($urandom_range(0, 1)));
            for (i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    command(i2cmbs_pkg::MODE_TICK + 3'($urandom_range(1, 7)), pick_byte(),
                            1'($urandom_range(0, 1)));
                tick(1'($urandom_range(0, 1)));
            end
            repeat ($urandom_range(0, 2))
                tick(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_noise();
        int i;
        begin
            for (i = $urandom_range(1, 6); i > 0; i--)
                send_item(3'($urandom_range(0, 7)), BW'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        m_axis_tready = 1'b0;
        stalled_once  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && !stalled_once && results_seen >= STALL_AT)
            begin
                stalled_once = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (STALL_LEN - 1) @(negedge clk);
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14) - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial
    begin
        #2ms;
        $display("i2c_master_bit_sequencer_tb: FAIL");
        $finish;
    end

    initial
    begin
        sb            = new();
        items_sent    = 0;
        results_seen  = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = i2cmbs_pkg::MODE_TICK;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle ticks, reserved modes
        tick(1'b0);
        command(MODE_RSVD6, 8'hFF, 1'b1);
        command(MODE_RSVD7, 8'h00, 1'b0);
        tick(1'b1);
        // start, with a stop arriving while busy
        command(i2cmbs_pkg::MODE_START, 8'h00, 1'b0);
        tick(1'b0);
        command(i2cmbs_pkg::MODE_STOP, 8'hFF, 1'b1);
        repeat (START_TICKS - 1) tick(1'b1);
        // wait ack: nack seen, SCL left high
        command(i2cmbs_pkg::MODE_WAIT, 8'hFF, 1'b1);
        repeat (WAIT_TICKS - 1) tick(1'b0);
        tick(1'b1);
        // wait ack: ack seen
        command(i2cmbs_pkg::MODE_WAIT, 8'h00, 1'b0);
        repeat (WAIT_TICKS - 1) tick(1'b1);
        tick(1'b0);
        command(i2cmbs_pkg::MODE_STOP, 8'h00, 1'b0);
        repeat (STOP_TICKS) tick(1'b0);

        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent >= QUIET_AFTER)
                quiet = 1'b1;
            if ($urandom_range(0, 6) == 0)
                run_noise();
            else
                run_sequence();
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);

        $display("%0d items sent, %0d tick results checked, %0d commands completed",
                 items_sent, sb.checked, sb.completions);
        $display("covered idle ticks, reserved and overlapping commands, long output stall");
        if (sb.fails == 0 && sb.pending() == 0)
            $display("i2c_master_bit_sequencer_tb: PASS");
        else
            $display("i2c_master_bit_sequencer_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hdl/i2cmbs_pkg.sv
hdl/i2c_master_bit_sequencer.sv
bench/i2c_master_bit_sequencer_tb.sv
